FILE: rtl/core/merge_sort_engine_unit_assert.svh
// Assertion macros shared by the merge sort engine RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef MERGE_SORT_ENGINE_UNIT_ASSERT_SVH
`define MERGE_SORT_ENGINE_UNIT_ASSERT_SVH

// Checked on every edge once reset is released.
`define MSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define MSE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/core/mse_pkg.sv
// Shared types and constants of the merge sort engine.
// No dependencies.
`default_nettype none

package mse_pkg;

  localparam int unsigned MAX_ELEMENTS = 64;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int unsigned CNT_W        = $clog2(MAX_ELEMENTS + 1);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [ADDR_W-1:0]        addr_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETUP,
    ST_MERGE,
    ST_EMIT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;        // store the accepted beat
    logic setup;       // open the next pair of runs
    logic merge;       // move one element into the other bank
    logic emit_start;  // sort finished, rewind the read index
    logic emit;        // load the output register
    logic clear;       // set finished, back to an empty store
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic load_close;
    logic merge_last;
    logic pass_last;
    logic sort_last;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/mse_if.sv
// Valid/ready stream interfaces for the input and result channels.
// Depends on mse_pkg.
`default_nettype none

interface mse_in_if import mse_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t value;
  logic  last_in;

  modport source (output valid, output value, output last_in, input ready);
  modport sink   (input valid, input value, input last_in, output ready);
endinterface

interface mse_out_if import mse_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t sorted_value;
  logic  last_out;

  modport source (output valid, output sorted_value, output last_out, input ready);
  modport sink   (input valid, input sorted_value, input last_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/mse_ram.sv
// Generic RAM: one write port, two registered read ports.
// A read of the address being written returns the new data. No dependencies.
`default_nettype none

module mse_ram #(
  parameter  int unsigned Width = 32,
  parameter  int unsigned Depth = 64,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_a_i,
  output logic      [Width-1:0] rdata_a_o,
  input  wire logic [AddrW-1:0] raddr_b_i,
  output logic      [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= (we_i && (waddr_i == raddr_a_i)) ? wdata_i : mem_q[raddr_a_i];
    rdata_b_o <= (we_i && (waddr_i == raddr_b_i)) ? wdata_i : mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

FILE: rtl/core/mse_ctrl.sv
// Sequencer of the merge sort engine: load, merge passes, emission.
// Depends on mse_pkg.
`default_nettype none

module mse_ctrl import mse_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire sts_t sts_i,
  output logic      in_ready_o,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.load_close) begin
            state_d = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_MERGE;
      end
      ST_MERGE: begin
        cmd_o.merge = 1'b1;
        if (sts_i.merge_last) begin
          if (sts_i.pass_last && sts_i.sort_last) begin
            cmd_o.emit_start = 1'b1;
            state_d          = ST_EMIT;
          end else begin
            state_d = ST_SETUP;
          end
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.emit_last) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/mse_dp.sv
// Datapath of the merge sort engine: two RAM banks used ping-pong, run
// indices, merge compare and the output register.
// Depends on mse_pkg, mse_ram and the assertion macro header.
`default_nettype none
`include "merge_sort_engine_unit_assert.svh"

module mse_dp import mse_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cmd_t  cmd_i,
  input  wire data_t in_value_i,
  input  wire logic  in_last_i,
  input  wire logic  out_ready_i,
  output sts_t       sts_o,
  output logic       out_valid_o,
  output data_t      out_value_o,
  output logic       out_last_o
);

  cnt_t  count_q, count_d;
  cnt_t  width_q, width_d;
  cnt_t  lo_q, lo_d;
  cnt_t  mid_q, mid_d;
  cnt_t  hi_q, hi_d;
  cnt_t  l_q, l_d;
  cnt_t  r_q, r_d;
  cnt_t  w_q, w_d;
  logic  src_q, src_d;     // bank holding the current runs
  logic  out_valid_q, out_valid_d;
  data_t out_value_q;
  logic  out_last_q;

  logic [CNT_W:0] mid_sum, hi_sum, width_x2;
  cnt_t  mid_new, hi_new;
  logic  left_ok, right_ok, take_left;
  data_t head_l, head_r, merge_data;
  data_t rd_a0, rd_b0, rd_a1, rd_b1;
  logic  we0, we1;
  addr_t waddr;
  data_t wdata;

  // run bounds for the next merge
  assign mid_sum  = {1'b0, lo_q} + {1'b0, width_q};
  assign hi_sum   = {1'b0, lo_q} + {width_q, 1'b0};
  assign width_x2 = {width_q, 1'b0};
  assign mid_new  = (mid_sum > {1'b0, count_q}) ? count_q : mid_sum[CNT_W-1:0];
  assign hi_new   = (hi_sum > {1'b0, count_q}) ? count_q : hi_sum[CNT_W-1:0];

  // heads of both runs: read data always belongs to l_q / r_q
  assign head_l     = src_q ? rd_a1 : rd_a0;
  assign head_r     = src_q ? rd_b1 : rd_b0;
  assign left_ok    = l_q < mid_q;
  assign right_ok   = r_q < hi_q;
  assign take_left  = left_ok && (!right_ok || (head_l <= head_r));
  assign merge_data = take_left ? head_l : head_r;

  assign sts_o.load_close = in_last_i || (count_q == CNT_W'(MAX_ELEMENTS - 1));
  assign sts_o.merge_last = (w_q + CNT_W'(1)) == hi_q;
  assign sts_o.pass_last  = hi_q == count_q;
  assign sts_o.sort_last  = width_x2 >= {1'b0, count_q};
  assign sts_o.emit_last  = (l_q + CNT_W'(1)) == count_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    count_d     = count_q;
    width_d     = width_q;
    lo_d        = lo_q;
    mid_d       = mid_q;
    hi_d        = hi_q;
    l_d         = l_q;
    r_d         = r_q;
    w_d         = w_q;
    src_d       = src_q;
    out_valid_d = out_valid_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load) begin
      count_d = count_q + CNT_W'(1);
    end
    if (cmd_i.setup) begin
      mid_d = mid_new;
      hi_d  = hi_new;
      l_d   = lo_q;
      r_d   = mid_new;
      w_d   = lo_q;
    end
    if (cmd_i.merge) begin
      if (take_left) begin
        l_d = l_q + CNT_W'(1);
      end else begin
        r_d = r_q + CNT_W'(1);
      end
      w_d = w_q + CNT_W'(1);
      if (sts_o.merge_last) begin
        lo_d = hi_q;
        if (sts_o.pass_last) begin
          lo_d    = '0;
          width_d = width_x2[CNT_W-1:0];
          src_d   = !src_q;
        end
      end
    end
    if (cmd_i.emit_start) begin
      l_d = '0;
    end
    if (cmd_i.emit) begin
      l_d         = l_q + CNT_W'(1);
      out_valid_d = 1'b1;
    end
    if (cmd_i.clear) begin
      count_d = '0;
      width_d = CNT_W'(1);
      lo_d    = '0;
      src_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      width_q     <= CNT_W'(1);
      lo_q        <= '0;
      mid_q       <= '0;
      hi_q        <= '0;
      l_q         <= '0;
      r_q         <= '0;
      w_q         <= '0;
      src_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      width_q     <= width_d;
      lo_q        <= lo_d;
      mid_q       <= mid_d;
      hi_q        <= hi_d;
      l_q         <= l_d;
      r_q         <= r_d;
      w_q         <= w_d;
      src_q       <= src_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_value_q <= head_l;
      out_last_q  <= sts_o.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

  // bank writes: loading fills bank 0, a merge writes the bank not read
  assign we0   = cmd_i.load || (cmd_i.merge && src_q);
  assign we1   = cmd_i.merge && !src_q;
  assign waddr = cmd_i.load ? count_q[ADDR_W-1:0] : w_q[ADDR_W-1:0];
  assign wdata = cmd_i.load ? in_value_i : merge_data;

  mse_ram #(
    .Width (DATA_W),
    .Depth (MAX_ELEMENTS)
  ) u_bank0 (
    .clk_i     (clk_i),
    .we_i      (we0),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (l_d[ADDR_W-1:0]),
    .rdata_a_o (rd_a0),
    .raddr_b_i (r_d[ADDR_W-1:0]),
    .rdata_b_o (rd_b0)
  );

  mse_ram #(
    .Width (DATA_W),
    .Depth (MAX_ELEMENTS)
  ) u_bank1 (
    .clk_i     (clk_i),
    .we_i      (we1),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (l_d[ADDR_W-1:0]),
    .rdata_a_o (rd_a1),
    .raddr_b_i (r_d[ADDR_W-1:0]),
    .rdata_b_o (rd_b1)
  );

  `MSE_ASSERT(a_count_bound, count_q <= CNT_W'(MAX_ELEMENTS), "element count above store depth")
  `MSE_ASSERT(a_merge_bounds, cmd_i.merge |-> (l_q <= mid_q && r_q <= hi_q && w_q < hi_q), "merge index out of its run")
  `MSE_ASSERT(a_emit_rewind, cmd_i.emit_start |=> (l_q == '0 && !cmd_i.merge), "emission does not start at element zero")

endmodule

`default_nettype wire

FILE: rtl/core/merge_sort_engine_unit.sv
// Merge sort engine. Values stream in on in_i, one beat per element, and
// are written in arrival order into bank 0 of two 64-entry RAM banks; the
// beat with last_in set, or the 64th beat, closes the set. The set is then
// sorted ascending (signed compare, stable: on equal keys the left run wins)
// by bottom-up merge passes whose run width doubles from 1. Each pass reads
// runs from one bank through its two read ports and writes the merged
// output to the other bank, one element per cycle, so no copy-back is
// needed. Every pair of runs is opened by a setup step while the RAM
// reads are primed. For n elements: the load, then P = max(1, ceil(log2 n))
// merge passes, then n emission beats on out_o with last_out on the final
// one. in_i is not ready from the closing beat until the last result has
// been loaded into the output register; that last result may still wait
// for out_o while the next set loads. There is no clearing pass after reset.
// Depends on mse_pkg, mse_if, mse_ctrl, mse_dp.
`default_nettype none

module merge_sort_engine_unit import mse_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mse_in_if.sink    in_i,
  mse_out_if.source out_o
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  // sequencer: owns the phase (load, merge passes, emission)
  mse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .sts_i      (sts),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  // storage, indices, compare and the output register
  mse_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_value_i  (in_i.value),
    .in_last_i   (in_i.last_in),
    .out_ready_i (out_o.ready),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .out_value_o (out_o.sorted_value),
    .out_last_o  (out_o.last_out)
  );

  assign in_i.ready = in_ready;

endmodule

`default_nettype wire
